### hw/rtl/bats_pkg.sv
// ----------------------------------------------------------------------------
// bats_pkg
// shared types and constants of the bilinear texture sampler
// ----------------------------------------------------------------------------
package bats_pkg;

  // field widths
  localparam int SIZE_W  = 7;   // texture size and stride registers
  localparam int WADDR_W = 12;  // write address field
  localparam int COORD_W = 17;  // q1.16 coordinate field
  localparam int FRAC_W  = 16;  // fraction bits of a coordinate
  localparam int SCL_W   = 23;  // coordinate times (size - 1)
  localparam int WGT_W   = 8;   // blend weight
  localparam int TEXEL_W = 32;
  localparam int RAW_W   = 14;  // unreduced texel address, row * stride + col

  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(65536);
  localparam logic [TEXEL_W-1:0] LANE_MASK = 32'h00FF00FF;
  localparam logic [WGT_W-1:0]   WGT_SCALE = 8'd255;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSED = 2'd3;

  localparam logic [SIZE_W-1:0] TEX_WIDTH_RST  = 7'd64;
  localparam logic [SIZE_W-1:0] TEX_HEIGHT_RST = 7'd64;
  localparam logic [SIZE_W-1:0] ROW_STRIDE_RST = 7'd64;

  // input action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // corner of the 2x2 footprint, fetched in this order
  localparam logic [1:0] CRN_TL = 2'd0;  // row0, col0
  localparam logic [1:0] CRN_TR = 2'd1;  // row0, col1
  localparam logic [1:0] CRN_BL = 2'd2;  // row1, col0
  localparam logic [1:0] CRN_BR = 2'd3;  // row1, col1

  // tag that travels with an address through the reduction pipe
  typedef struct packed {
    logic       is_write;
    logic [1:0] corner;
  } bats_tag_t;

  typedef struct packed {
    logic             valid;
    bats_tag_t        tag;
    logic [RAW_W-1:0] raw;
  } bats_areq_t;

  typedef struct packed {
    logic      valid;
    bats_tag_t tag;
  } bats_ares_t;

  // texel returning from the memory
  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
  } bats_texin_t;

endpackage

### hw/rtl/bats_tex_mem.sv
// ----------------------------------------------------------------------------
// bats_tex_mem
// single-port texel memory, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module bats_tex_mem
  import bats_pkg::*;
#(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic [TEXEL_W-1:0] wdata,
  output logic [TEXEL_W-1:0] rdata
);

  logic [TEXEL_W-1:0] mem [DEPTH];
  logic [TEXEL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/bats_addr_unit.sv
// ----------------------------------------------------------------------------
// bats_addr_unit
// reduces a raw texel address modulo the memory depth, three stages
// ----------------------------------------------------------------------------
module bats_addr_unit
  import bats_pkg::*;
#(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bats_areq_t    req,
  output bats_ares_t    rsp,
  output logic [AW-1:0] addr
);

  // quotient by reciprocal, exact for every raw value below 2**RAW_W
  localparam int SH = RAW_W + AW;
  localparam int MW = RAW_W + 2;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);
  localparam int PW = RAW_W + MW;
  localparam int DW = RAW_W + AW + 1;

  logic             v0_r, v1_r, v2_r;
  bats_tag_t        tag0_r, tag1_r, tag2_r;
  logic [RAW_W-1:0] raw0_r, raw1_r;
  logic [RAW_W-1:0] q1_r;
  logic [AW-1:0]    addr2_r;

  logic [PW-1:0] prod;
  logic [DW-1:0] qd;
  logic [DW-1:0] rem;

  assign prod = PW'(raw0_r) * PW'(RECIP);
  assign qd   = DW'(q1_r) * DW'(DEPTH);
  assign rem  = DW'(raw1_r) - qd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= req.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    tag0_r  <= req.tag;
    raw0_r  <= req.raw;
    tag1_r  <= tag0_r;
    raw1_r  <= raw0_r;
    q1_r    <= RAW_W'(prod >> SH);
    tag2_r  <= tag1_r;
    addr2_r <= rem[AW-1:0];
  end

  assign rsp.valid = v2_r;
  assign rsp.tag   = tag2_r;
  assign addr      = addr2_r;

endmodule

### hw/rtl/bats_blend.sv
// ----------------------------------------------------------------------------
// bats_blend
// packed two-lane lerps over the four corner texels
// ----------------------------------------------------------------------------
module bats_blend
  import bats_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bats_texin_t        tin,
  input  logic [TEXEL_W-1:0] texel,
  input  logic [WGT_W-1:0]   wu,
  input  logic [WGT_W-1:0]   wv,
  output logic               pix_valid,
  output logic [TEXEL_W-1:0] pixel
);

  function automatic logic [TEXEL_W-1:0] lerp(input logic [TEXEL_W-1:0] a,
                                               input logic [TEXEL_W-1:0] b,
                                               input logic [WGT_W-1:0]   w);
    logic [TEXEL_W-1:0] rb;
    logic [TEXEL_W-1:0] ga;
    logic [TEXEL_W-1:0] drb;
    logic [TEXEL_W-1:0] dga;
    logic [TEXEL_W-1:0] prb;
    logic [TEXEL_W-1:0] pga;
    rb  = a & LANE_MASK;
    ga  = (a >> 8) & LANE_MASK;
    drb = (b & LANE_MASK) - rb;
    dga = ((b >> 8) & LANE_MASK) - ga;
    // 32-bit wrapping products
    prb = drb * TEXEL_W'(w);
    pga = dga * TEXEL_W'(w);
    rb  = rb + (prb >> 8);
    ga  = ga + (pga >> 8);
    return (rb & LANE_MASK) | ((ga & LANE_MASK) << 8);
  endfunction

  logic [TEXEL_W-1:0] hold_r;
  logic [TEXEL_W-1:0] top_r;
  logic [TEXEL_W-1:0] bot_r;
  logic [TEXEL_W-1:0] pixel_r;
  logic               mix_r;
  logic               valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      mix_r   <= tin.valid && (tin.corner == CRN_BR);
      valid_r <= mix_r;
    end
    if (tin.valid) begin
      unique case (tin.corner)
        CRN_TL, CRN_BL: hold_r <= texel;
        CRN_TR:         top_r  <= lerp(hold_r, texel, wu);
        CRN_BR:         bot_r  <= lerp(hold_r, texel, wu);
        default:        hold_r <= texel;
      endcase
    end
    if (mix_r) begin
      pixel_r <= lerp(top_r, bot_r, wv);
    end
  end

  assign pix_valid = valid_r;
  assign pixel     = pixel_r;

endmodule

### hw/rtl/bilinear_argb_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_argb_texture_sampler
// bilinear filtered lookup into a texture of 32-bit argb texels
// ----------------------------------------------------------------------------
// One item at a time: busy rises the cycle after start is taken and falls when
// the item is finished. The pixel of a sample item appears on out_pixel with
// out_valid high for one cycle. The sample time is set by the single-port
// texel memory, which is read once per corner, plus the address reduction
// pipe (3 stages), the memory read register and the two lerp stages. Results
// cannot be stalled: sample out_valid every cycle it is high. Coordinates are
// unsigned q1.16 and saturate at 1.0; a size of 0 is taken as 1; every
// address wraps modulo the memory depth. Reading a texel that was never
// written gives an undefined pixel. Configuration may be written at any time
// but only takes effect cleanly while busy is low.
// ----------------------------------------------------------------------------
module bilinear_argb_texture_sampler
  import bats_pkg::*;
#(
  parameter int TEX_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_action,
  input  logic [WADDR_W-1:0]   in_texel_address,
  input  logic [TEXEL_W-1:0]   in_texel_value,
  input  logic [COORD_W-1:0]   in_coord_x,
  input  logic [COORD_W-1:0]   in_coord_y,
  // result channel
  output logic                 out_valid,
  output logic [TEXEL_W-1:0]   out_pixel,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(TEX_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AXIS,
    ST_FEED,
    ST_DRAIN
  } state_t;

  // configuration registers
  logic [SIZE_W-1:0] tex_width_r;
  logic [SIZE_W-1:0] tex_height_r;
  logic [SIZE_W-1:0] row_stride_r;
  logic              transposed_r;

  // sequencer
  state_t     state_r;
  logic [1:0] corner_r;

  // per-item registers
  logic [TEXEL_W-1:0] wdata_r;
  logic [SCL_W-1:0]   scl_x_r, scl_y_r;
  logic [SIZE_W-1:0]  col0_r, col1_r, row0_r, row1_r;
  logic [WGT_W-1:0]   wu_r, wv_r;

  // memory read return
  bats_texin_t rd_r;

  logic               accept;
  logic [SIZE_W-1:0]  last_x, last_y;
  logic [COORD_W-1:0] cx, cy;
  logic [SIZE_W-1:0]  base_x, base_y;
  logic [23:0]        wprod_x, wprod_y;
  logic [SIZE_W-1:0]  row_sel, col_sel, mul_a, add_b;
  logic [RAW_W-1:0]   raw_rd;
  bats_areq_t         areq;
  bats_ares_t         arsp;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [TEXEL_W-1:0] mem_rdata;
  logic               pix_valid;
  logic [TEXEL_W-1:0] pixel;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= TEX_WIDTH_RST;
      tex_height_r <= TEX_HEIGHT_RST;
      row_stride_r <= ROW_STRIDE_RST;
      transposed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        CFG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        CFG_ROW_STRIDE: row_stride_r <= cfg_wdata;
        CFG_TRANSPOSED: transposed_r <= cfg_wdata[0];
        default:        transposed_r <= transposed_r;
      endcase
    end
  end

  // last texel index per axis, a size of zero acts as one
  assign last_x = (tex_width_r == '0) ? '0 : tex_width_r - SIZE_W'(1);
  assign last_y = (tex_height_r == '0) ? '0 : tex_height_r - SIZE_W'(1);

  // coordinates saturate at 1.0
  assign cx = (in_coord_x > COORD_ONE) ? COORD_ONE : in_coord_x;
  assign cy = (in_coord_y > COORD_ONE) ? COORD_ONE : in_coord_y;

  // integer part is the base index, fraction makes the 8-bit weight
  assign base_x  = scl_x_r[SCL_W-1:FRAC_W];
  assign base_y  = scl_y_r[SCL_W-1:FRAC_W];
  assign wprod_x = 24'(scl_x_r[FRAC_W-1:0]) * 24'(WGT_SCALE);
  assign wprod_y = 24'(scl_y_r[FRAC_W-1:0]) * 24'(WGT_SCALE);

  // raw address of the corner being fed: row*stride+col, or row+stride*col
  assign row_sel = corner_r[1] ? row1_r : row0_r;
  assign col_sel = corner_r[0] ? col1_r : col0_r;
  assign mul_a   = transposed_r ? col_sel : row_sel;
  assign add_b   = transposed_r ? row_sel : col_sel;
  assign raw_rd  = (RAW_W'(mul_a) * RAW_W'(row_stride_r)) + RAW_W'(add_b);

  // requests into the address pipe: a write right at accept, reads while feeding
  always_comb begin
    areq.valid        = 1'b0;
    areq.tag.is_write = 1'b0;
    areq.tag.corner   = corner_r;
    areq.raw          = raw_rd;
    if (accept && (in_action == ACT_WRITE)) begin
      areq.valid        = 1'b1;
      areq.tag.is_write = 1'b1;
      areq.raw          = RAW_W'(in_texel_address);
    end else if (state_r == ST_FEED) begin
      areq.valid = 1'b1;
    end
  end

  // sequencer, one item in flight at a time so no access overlaps a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      corner_r <= CRN_TL;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          corner_r <= CRN_TL;
          if (accept) begin
            state_r <= (in_action == ACT_WRITE) ? ST_DRAIN : ST_AXIS;
          end
        end
        ST_AXIS: begin
          state_r <= ST_FEED;
        end
        ST_FEED: begin
          corner_r <= corner_r + 2'd1;
          if (corner_r == CRN_BR) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // write done when it reaches the memory, sample when the pixel goes out
          if (mem_we || pix_valid) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // item payload, captured at accept and derived in the axis step
  always_ff @(posedge clk) begin
    if (accept) begin
      wdata_r <= in_texel_value;
      scl_x_r <= SCL_W'(cx) * SCL_W'(last_x);
      scl_y_r <= SCL_W'(cy) * SCL_W'(last_y);
    end
    if (state_r == ST_AXIS) begin
      col0_r <= base_x;
      col1_r <= base_x + ((base_x < last_x) ? SIZE_W'(1) : SIZE_W'(0));
      row0_r <= base_y;
      row1_r <= base_y + ((base_y < last_y) ? SIZE_W'(1) : SIZE_W'(0));
      wu_r   <= wprod_x[23:16];
      wv_r   <= wprod_y[23:16];
    end
  end

  bats_addr_unit #(
    .DEPTH (TEX_DEPTH)
  ) u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp),
    .addr  (mem_addr)
  );

  assign mem_we = arsp.valid && arsp.tag.is_write;

  bats_tex_mem #(
    .DEPTH (TEX_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wdata_r),
    .rdata (mem_rdata)
  );

  // read data is registered in the memory, the tag is registered to match it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r.valid <= 1'b0;
    end else begin
      rd_r.valid <= arsp.valid && !arsp.tag.is_write;
    end
    rd_r.corner <= arsp.tag.corner;
  end

  bats_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .tin       (rd_r),
    .texel     (mem_rdata),
    .wu        (wu_r),
    .wv        (wv_r),
    .pix_valid (pix_valid),
    .pixel     (pixel)
  );

  assign out_valid = pix_valid;
  assign out_pixel = pixel;

endmodule
